// ===== rtl/vn3_pkg.sv =====
// ============================================================================
// vn3_pkg: shared types and constants of the 3-D vector normalizer
// Holds the coordinate widths, the default output precision and the side-band
// record that travels with every point down the pipeline.
// ============================================================================
package vn3_pkg;

    localparam int COORD_W            = 32;
    localparam int UNIT_W             = 32;
    localparam int SUM_W              = 64;
    localparam int OUT_FRAC_BITS_DEF  = 30;

    // Side-band data that follows a point through every stage.
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
        logic       last;
    } meta_t;

endpackage

// ===== rtl/vn3_in_if.sv =====
// ============================================================================
// vn3_in_if: point channel
// Valid/ready channel that carries one point per beat.
// ============================================================================
interface vn3_in_if;
    import vn3_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_point;

    modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

// ===== rtl/vn3_out_if.sv =====
// ============================================================================
// vn3_out_if: unit vector channel
// Valid/ready channel that carries one unit vector per beat.
// ============================================================================
interface vn3_out_if;
    import vn3_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic                     zero_length;
    logic                     last_out;

    modport source (output valid, unit_x, unit_y, unit_z, zero_length, last_out,
                    input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, zero_length, last_out,
                    output ready);
endinterface

// ===== rtl/vn3_prep.sv =====
// ============================================================================
// vn3_prep: front end of the normalizer
// Takes magnitudes and signs, squares them, sums the squares and seeds the
// residual and the running product for the bit cells.
// ============================================================================
module vn3_prep #(
    parameter int F  = vn3_pkg::OUT_FRAC_BITS_DEF,
    parameter int WW = 2 * F + 72
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [vn3_pkg::COORD_W-1:0] coord [3],
    input  logic                              last_point,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vn3_pkg::SUM_W-1:0]         sum,
    output logic signed [WW-1:0]              rem [3],
    output logic signed [WW-1:0]              ts [3],
    output vn3_pkg::meta_t                    meta
);
    import vn3_pkg::*;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                 s1_ready, s2_ready, s3_ready;
    logic [COORD_W-1:0]   mag_reg [3];
    logic [SUM_W-1:0]     sq_reg [3];
    logic [SUM_W-1:0]     sum_reg;
    logic signed [WW-1:0] rem_reg [3];
    logic signed [WW-1:0] ts_reg [3];
    meta_t                m1_reg, m2_reg, m3_reg;
    logic [SUM_W-1:0]     sum_next;
    logic signed [WW-1:0] sum_ext;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    assign sum_ext  = $signed({{(WW-SUM_W){1'b0}}, sum_next});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_ready && in_valid) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i]   <= coord[i][COORD_W-1] ? (~coord[i] + 1'b1) : coord[i];
                m1_reg.neg[i] <= coord[i][COORD_W-1];
            end
            m1_reg.zero <= (coord[0] == '0) && (coord[1] == '0) && (coord[2] == '0);
            m1_reg.last <= last_point;
        end
        if (s2_ready && s1_valid_reg) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= mag_reg[i] * mag_reg[i];
            end
            m2_reg <= m1_reg;
        end
        if (s3_ready && s2_valid_reg) begin
            sum_reg <= sum_next;
            for (int i = 0; i < 3; i++) begin
                // Residual a^2 * 4^(F+1) - t^2 * S with t = -1 to start.
                rem_reg[i] <= ($signed({{(WW-SUM_W){1'b0}}, sq_reg[i]}) <<< (2 * F + 2))
                              - sum_ext;
                ts_reg[i]  <= -sum_ext;
            end
            m3_reg <= m2_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign sum       = sum_reg;
    assign rem       = rem_reg;
    assign ts        = ts_reg;
    assign meta      = m3_reg;
endmodule

// ===== rtl/vn3_cell.sv =====
// ============================================================================
// vn3_cell: one result bit of the normalizer
// Tries to set bit K of each component's quotient and keeps it when the
// residual stays non-negative, then hands everything to the next cell.
// ============================================================================
module vn3_cell #(
    parameter int F  = vn3_pkg::OUT_FRAC_BITS_DEF,
    parameter int WW = 2 * F + 72,
    parameter int K  = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [vn3_pkg::SUM_W-1:0] sum_in,
    input  logic signed [WW-1:0]      rem_in [3],
    input  logic signed [WW-1:0]      ts_in [3],
    input  logic [F:0]                q_in [3],
    input  vn3_pkg::meta_t            meta_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [vn3_pkg::SUM_W-1:0] sum_out,
    output logic signed [WW-1:0]      rem_out [3],
    output logic signed [WW-1:0]      ts_out [3],
    output logic [F:0]                q_out [3],
    output vn3_pkg::meta_t            meta_out
);
    import vn3_pkg::*;

    logic                 valid_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic signed [WW-1:0] rem_reg [3];
    logic signed [WW-1:0] ts_reg [3];
    logic [F:0]           q_reg [3];
    meta_t                meta_reg;
    logic signed [WW-1:0] sum_ext;
    logic signed [WW-1:0] trial [3];
    logic signed [WW-1:0] rem_next [3];
    logic signed [WW-1:0] ts_next [3];
    logic [F:0]           q_next [3];

    assign in_ready = !valid_reg || out_ready;
    assign sum_ext  = $signed({{(WW-SUM_W){1'b0}}, sum_in});

    // Raising q by 2^K grows t = 2q-1 by 2^(K+1), so t^2*S grows by
    // 2^(K+2)*t*S + 4^(K+1)*S.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            trial[i] = rem_in[i] - (ts_in[i] <<< (K + 2)) - (sum_ext <<< (2 * K + 2));
            if (!trial[i][WW-1]) begin
                rem_next[i] = trial[i];
                ts_next[i]  = ts_in[i] + (sum_ext <<< (K + 1));
                q_next[i]   = q_in[i] | ((F + 1)'(1) << K);
            end
            else begin
                rem_next[i] = rem_in[i];
                ts_next[i]  = ts_in[i];
                q_next[i]   = q_in[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid) begin
            sum_reg  <= sum_in;
            rem_reg  <= rem_next;
            ts_reg   <= ts_next;
            q_reg    <= q_next;
            meta_reg <= meta_in;
        end
    end

    assign out_valid = valid_reg;
    assign sum_out   = sum_reg;
    assign rem_out   = rem_reg;
    assign ts_out    = ts_reg;
    assign q_out     = q_reg;
    assign meta_out  = meta_reg;
endmodule

// ===== rtl/vector_normalizer_3d.sv =====
// ============================================================================
// vector_normalizer_3d: streaming unit vector of a 3-D point
// Turns each signed Q16.16 point into its rounded signed unit vector.
// ============================================================================
// The block has two valid/ready channels. A point beat on "points" carries
// coord_x, coord_y, coord_z and last_point; a result beat on "units" carries
// unit_x, unit_y, unit_z with OUT_FRAC_BITS fraction bits, zero_length and
// last_out. Each component is round-half-away-from-zero of
// v * 2^OUT_FRAC_BITS / |v|, computed exactly with integer arithmetic.
// A zero point gives zero components with zero_length set.
//
// The pipeline has three front-end stages (magnitude, square, sum), one
// cell for each of the OUT_FRAC_BITS + 1 quotient bits, and the output
// register. Throughput is one point per cycle while units takes its beats;
// the rate is set by the row of bit cells, each of which resolves one bit of
// all three components with a wide subtract and sign test, then passes it on.
//
// Every stage holds its own valid bit and stalls only when it is full and the
// stage after it cannot take its beat, so a stalled receiver fills the pipe
// before points stops accepting beats. Reset empties every stage; the data
// registers are not reset. Beats come out in the order they went in.
// ============================================================================
module vector_normalizer_3d #(
    parameter int OUT_FRAC_BITS = vn3_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    vn3_in_if.sink    points,
    vn3_out_if.source units
);
    import vn3_pkg::*;

    localparam int F     = OUT_FRAC_BITS;
    localparam int WW    = 2 * F + 72;
    localparam int NCELL = F + 1;

    logic signed [COORD_W-1:0] coord [3];

    // Links between the front end, the cells and the output stage.
    logic                 lv  [NCELL+1];
    logic                 lr  [NCELL+1];
    logic [SUM_W-1:0]     ls  [NCELL+1];
    logic signed [WW-1:0] lrem [NCELL+1][3];
    logic signed [WW-1:0] lts  [NCELL+1][3];
    logic [F:0]           lq   [NCELL+1][3];
    meta_t                lm  [NCELL+1];

    logic                     out_valid_reg;
    logic                     out_take;
    logic signed [UNIT_W-1:0] unit_reg [3];
    logic                     zero_reg;
    logic                     last_reg;
    logic signed [UNIT_W-1:0] unit_next [3];

    assign coord[0] = points.coord_x;
    assign coord[1] = points.coord_y;
    assign coord[2] = points.coord_z;

    vn3_prep #(.F(F), .WW(WW)) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (points.valid),
        .in_ready   (points.ready),
        .coord      (coord),
        .last_point (points.last_point),
        .out_valid  (lv[0]),
        .out_ready  (lr[0]),
        .sum        (ls[0]),
        .rem        (lrem[0]),
        .ts         (lts[0]),
        .meta       (lm[0])
    );

    // The quotient starts at zero ahead of the first cell.
    assign lq[0][0] = '0;
    assign lq[0][1] = '0;
    assign lq[0][2] = '0;

    // Cell j decides quotient bit F - j, most significant first.
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        vn3_cell #(.F(F), .WW(WW), .K(F - j)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lv[j]),
            .in_ready  (lr[j]),
            .sum_in    (ls[j]),
            .rem_in    (lrem[j]),
            .ts_in     (lts[j]),
            .q_in      (lq[j]),
            .meta_in   (lm[j]),
            .out_valid (lv[j+1]),
            .out_ready (lr[j+1]),
            .sum_out   (ls[j+1]),
            .rem_out   (lrem[j+1]),
            .ts_out    (lts[j+1]),
            .q_out     (lq[j+1]),
            .meta_out  (lm[j+1])
        );
    end

    // Output stage: apply the signs and force zeros for a zero point. The
    // quotient never exceeds 2^F, so it fits the signed result with room.
    assign out_take    = !out_valid_reg || units.ready;
    assign lr[NCELL]   = out_take;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (lm[NCELL].zero) begin
                unit_next[i] = '0;
            end
            else if (lm[NCELL].neg[i]) begin
                unit_next[i] = -$signed({{(UNIT_W-F-1){1'b0}}, lq[NCELL][i]});
            end
            else begin
                unit_next[i] = $signed({{(UNIT_W-F-1){1'b0}}, lq[NCELL][i]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take) begin
            out_valid_reg <= lv[NCELL];
        end
    end

    always_ff @(posedge clk) begin
        if (out_take && lv[NCELL]) begin
            unit_reg <= unit_next;
            zero_reg <= lm[NCELL].zero;
            last_reg <= lm[NCELL].last;
        end
    end

    assign units.valid       = out_valid_reg;
    assign units.unit_x      = unit_reg[0];
    assign units.unit_y      = unit_reg[1];
    assign units.unit_z      = unit_reg[2];
    assign units.zero_length = zero_reg;
    assign units.last_out    = last_reg;
endmodule
